### rtl/core/cpfd_pkg.sv
// cpfd_pkg: types and constants for the color pulse frame decoder
// no dependencies; imported by color_pulse_frame_decoder
package cpfd_pkg;

  localparam int unsigned TS_W    = 32;
  localparam int unsigned GAP_W   = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned NUM_CH  = 4;

  localparam logic [GAP_W-1:0] GAP_THRESHOLD_RESET = 16'd122;

  // decoder phase; codes 5 to 7 are never entered
  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_RED    = 3'd1,
    PH_GREEN  = 3'd2,
    PH_BLUE   = 3'd3,
    PH_BRIGHT = 3'd4
  } phase_t;

  typedef struct packed {
    logic            pin_level;
    logic [TS_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red_value;
    logic [BYTE_W-1:0] green_value;
    logic [BYTE_W-1:0] blue_value;
    logic [BYTE_W-1:0] bright_value;
    logic              frame_done;
  } out_item_t;

endpackage

### rtl/core/color_pulse_frame_decoder.sv
// color_pulse_frame_decoder: one-wire color sensor pulse frame decoder
// depends on cpfd_pkg for the request types, phase enum and reset constants
//
// usage
//  - input channel (in_valid / in_ready / in_data) takes one line sample per
//    request: pin_level and a wrapping millisecond timestamp now_ms
//  - output channel (out_valid / out_ready / out_data) returns exactly one
//    result per input request: the four stored channel bytes and frame_done,
//    which is set on the request that stored the brightness slot
//  - cfg_we / cfg_wdata write the gap threshold in ms; write only while idle
//  - path: the accepting edge loads the input register, and the decode step
//    then moves the request into the result register once that is free or
//    being emptied
//  - throughput: one request per cycle unless the receiver stalls; the decode
//    step is one 32-bit subtract, compare and add between the two registers
//  - when the receiver stalls, the result register holds and the input
//    register still takes one more request; in_ready drops only when both
//    are full
//  - synchronous reset clears the decoder to hunting, all sums, timestamps
//    and channel bytes to zero, and the threshold to 122 ms
module color_pulse_frame_decoder
  import cpfd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [GAP_W-1:0] cfg_wdata
);

  // configuration
  logic [GAP_W-1:0] gap_threshold;

  // input register
  in_item_t in_q;
  logic     in_q_valid;

  // decoder state
  phase_t            phase, phase_next;
  logic [TS_W-1:0]   mark_time, mark_time_next;
  logic [TS_W-1:0]   low_sum, low_sum_next;
  logic [TS_W-1:0]   high_sum, high_sum_next;
  logic              in_slot, in_slot_next;
  logic              slot_ending, slot_ending_next;
  logic [BYTE_W-1:0] chan [NUM_CH];
  logic [BYTE_W-1:0] chan_next [NUM_CH];
  logic              done_next;

  // step operands
  logic            high;
  logic [TS_W-1:0] elapsed;
  logic            gap_seen;
  logic            advance;

  // the step fires when a sample is held and the result slot is free or
  // being emptied this cycle
  assign advance  = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;

  assign high     = in_q.pin_level;
  assign elapsed  = in_q.now_ms - mark_time;  // wraps modulo 2^32
  assign gap_seen = elapsed > {{(TS_W-GAP_W){1'b0}}, gap_threshold};

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_threshold <= GAP_THRESHOLD_RESET;
    end else if (cfg_we) begin
      gap_threshold <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= in_data;
    end
  end

  // phase sequencing: gap arms red, each stored slot steps to the next color
  always_comb begin
    phase_next = phase;
    if (phase == PH_HUNT) begin
      if (high && gap_seen) begin
        phase_next = PH_RED;
      end
    end else if (in_slot && !high && slot_ending) begin
      case (phase)
        PH_RED:    phase_next = PH_GREEN;
        PH_GREEN:  phase_next = PH_BLUE;
        PH_BLUE:   phase_next = PH_BRIGHT;
        PH_BRIGHT: phase_next = PH_HUNT;
        default:   phase_next = phase;
      endcase
    end
  end

  // slot timing and channel store
  always_comb begin
    mark_time_next   = mark_time;
    low_sum_next     = low_sum;
    high_sum_next    = high_sum;
    in_slot_next     = in_slot;
    slot_ending_next = slot_ending;
    done_next        = 1'b0;
    for (int i = 0; i < NUM_CH; i++) begin
      chan_next[i] = chan[i];
    end

    if (phase == PH_HUNT) begin
      in_slot_next     = 1'b0;
      slot_ending_next = 1'b0;
      if (!high) begin
        mark_time_next = in_q.now_ms;
      end
    end else if (in_slot) begin
      if (!high) begin
        if (slot_ending) begin
          // falling edge after an ending slot: store the low time byte
          case (phase)
            PH_RED:    chan_next[0] = low_sum[BYTE_W-1:0];
            PH_GREEN:  chan_next[1] = low_sum[BYTE_W-1:0];
            PH_BLUE:   chan_next[2] = low_sum[BYTE_W-1:0];
            PH_BRIGHT: begin
              chan_next[3] = low_sum[BYTE_W-1:0];
              done_next    = 1'b1;
            end
            default:   done_next = 1'b0;
          endcase
          slot_ending_next = 1'b0;
          low_sum_next     = '0;
          high_sum_next    = '0;
        end else begin
          low_sum_next = low_sum + elapsed;
        end
      end else begin
        // high with both sums running marks the end of the slot
        if (low_sum != '0 && high_sum != '0) begin
          slot_ending_next = 1'b1;
        end
        high_sum_next = high_sum + elapsed;
      end
      mark_time_next = in_q.now_ms;
    end else if (!high) begin
      // first falling level after arming opens a slot
      mark_time_next = in_q.now_ms;
      in_slot_next   = 1'b1;
      low_sum_next   = '0;
      high_sum_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      mark_time   <= '0;
      low_sum     <= '0;
      high_sum    <= '0;
      in_slot     <= 1'b0;
      slot_ending <= 1'b0;
      for (int i = 0; i < NUM_CH; i++) begin
        chan[i] <= '0;
      end
    end else if (advance) begin
      phase       <= phase_next;
      mark_time   <= mark_time_next;
      low_sum     <= low_sum_next;
      high_sum    <= high_sum_next;
      in_slot     <= in_slot_next;
      slot_ending <= slot_ending_next;
      for (int i = 0; i < NUM_CH; i++) begin
        chan[i] <= chan_next[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.red_value    <= chan_next[0];
      out_data.green_value  <= chan_next[1];
      out_data.blue_value   <= chan_next[2];
      out_data.bright_value <= chan_next[3];
      out_data.frame_done   <= done_next;
    end
  end

`ifndef ASSERT_OFF
  a_done_returns_to_hunt: assert property (@(posedge clk) disable iff (rst)
    advance && done_next |=> phase == PH_HUNT)
    else $error("frame done without return to hunting");

  a_ending_inside_slot: assert property (@(posedge clk) disable iff (rst)
    slot_ending |-> in_slot && phase != PH_HUNT)
    else $error("slot ending flag outside an open slot");

  a_step_fills_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("decode step did not load the result register");

  a_state_holds_when_idle: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(phase) && $stable(mark_time) && $stable(low_sum))
    else $error("decoder state changed without a step");
`endif

endmodule

### dv/tb.sv
// tb: self-checking bench for color_pulse_frame_decoder, with a cycle-free decode
// predictor, a queued request driver, a result monitor and threshold sweeps
// depends on cpfd_pkg and rtl/core/color_pulse_frame_decoder.sv
`timescale 1ns / 100ps

module tb;
  import cpfd_pkg::*;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // block ports; the inputs are driven to known values from time zero
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_we    = 1'b0;
  logic [GAP_W-1:0] cfg_wdata = '0;

  color_pulse_frame_decoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // line sample requests waiting to be driven, and decoded colors waiting
  // for the block to return them
  in_item_t  pending_samples [$];
  out_item_t expected_colors [$];

  int unsigned err_count     = 0;
  int unsigned result_count  = 0;
  int unsigned queued_count  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // timestamp cursor used while building stimulus
  logic [TS_W-1:0] stim_ts = '0;

  // ---------------------------------------------------------------------------
  // decoder model state, mirrors the block after reset
  // ---------------------------------------------------------------------------
  logic [GAP_W-1:0]  gap_thr      = GAP_THRESHOLD_RESET;
  phase_t            dec_phase    = PH_HUNT;
  logic [TS_W-1:0]   mark_ts      = '0;
  logic [TS_W-1:0]   low_acc      = '0;
  logic [TS_W-1:0]   high_acc     = '0;
  logic              slot_open    = 1'b0;
  logic              slot_closing = 1'b0;
  logic [BYTE_W-1:0] ch_bytes [NUM_CH] = '{default: '0};

  // decode one accepted line sample and queue the color set it produces
  function automatic void decode_sample(input in_item_t s);
    logic [TS_W-1:0] elapsed;
    out_item_t       r;
    elapsed      = s.now_ms - mark_ts;   // wraps modulo 2^32
    r.frame_done = 1'b0;
    if (dec_phase == PH_HUNT) begin
      // hunting: a long enough high gap since the last low arms red
      slot_open    = 1'b0;
      slot_closing = 1'b0;
      if (s.pin_level) begin
        if (elapsed > {{(TS_W-GAP_W){1'b0}}, gap_thr}) dec_phase = PH_RED;
      end else begin
        mark_ts = s.now_ms;
      end
    end else if (slot_open) begin
      if (!s.pin_level) begin
        if (slot_closing) begin
          // first low after the slot end: latch the low time byte
          ch_bytes[int'(dec_phase) - 1] = low_acc[BYTE_W-1:0];
          if (dec_phase == PH_BRIGHT) begin
            dec_phase    = PH_HUNT;
            r.frame_done = 1'b1;
          end else begin
            dec_phase = phase_t'(dec_phase + 3'd1);
          end
          slot_closing = 1'b0;
          low_acc      = '0;
          high_acc     = '0;
        end else begin
          low_acc += elapsed;
        end
      end else begin
        // slot ends only once both low and high time were seen
        if (low_acc != '0 && high_acc != '0) slot_closing = 1'b1;
        high_acc += elapsed;
      end
      mark_ts = s.now_ms;
    end else if (!s.pin_level) begin
      // armed phase, falling level opens the first slot
      mark_ts   = s.now_ms;
      slot_open = 1'b1;
      low_acc   = '0;
      high_acc  = '0;
    end
    r.red_value    = ch_bytes[0];
    r.green_value  = ch_bytes[1];
    r.blue_value   = ch_bytes[2];
    r.bright_value = ch_bytes[3];
    expected_colors.push_back(r);
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR @%0t result %0d: %s", $time, result_count, msg);
    err_count++;
  endtask

  task automatic check_color(input out_item_t got, input out_item_t want);
    if (got.red_value !== want.red_value)
      flag_error($sformatf("red_value got %0h want %0h", got.red_value, want.red_value));
    if (got.green_value !== want.green_value)
      flag_error($sformatf("green_value got %0h want %0h", got.green_value,
                           want.green_value));
    if (got.blue_value !== want.blue_value)
      flag_error($sformatf("blue_value got %0h want %0h", got.blue_value, want.blue_value));
    if (got.bright_value !== want.bright_value)
      flag_error($sformatf("bright_value got %0h want %0h", got.bright_value,
                           want.bright_value));
    if (got.frame_done !== want.frame_done)
      flag_error($sformatf("frame_done got %0b want %0b", got.frame_done, want.frame_done));
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents queued requests, holds them until accepted, and feeds
  // every accepted request to the decode model
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) decode_sample(in_data);
      // only move on once the current request is gone (or none is up)
      if (!in_valid || in_ready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_samples.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every accepted result is checked against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_colors.size() == 0) flag_error("result with nothing expected");
        else check_color(out_data, expected_colors.pop_front());
        result_count++;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_sample(input logic level, input logic [TS_W-1:0] ts);
    in_item_t s;
    s.pin_level = level;
    s.now_ms    = ts;
    pending_samples.push_back(s);
    queued_count++;
  endtask

  // move the timestamp cursor; now and then a huge jump so every bit of the
  // timestamp and the sums get exercised, wrap included
  function automatic logic [TS_W-1:0] advance(input int unsigned lo, input int unsigned hi);
    if ($urandom_range(31) == 0) stim_ts += $urandom();
    else stim_ts += $urandom_range(lo, hi);
    return stim_ts;
  endfunction

  // one frame: hunting gap, slot opener, then up to four color slots
  task automatic push_frame();
    logic [TS_W-1:0] base;
    int unsigned     n_slots;
    int unsigned     n;
    push_sample(1'b0, advance(1, 20));
    base = stim_ts;
    // sometimes land exactly on the threshold first, which must not arm
    if ($urandom_range(3) == 0) push_sample(1'b1, base + gap_thr);
    stim_ts = base + gap_thr + 1 + $urandom_range(0, 40);
    push_sample(1'b1, stim_ts);
    push_sample(1'b0, advance(0, 30));
    // broken frames stop after 0 to 3 slots
    n_slots = ($urandom_range(7) == 0) ? $urandom_range(0, 3) : NUM_CH;
    for (int i = 0; i < n_slots; i++) begin
      n = $urandom_range(1, 3);
      repeat (n) push_sample(1'b0, advance(0, 120));
      n = $urandom_range(2, 3);
      repeat (n) push_sample(1'b1, advance(0, 60));
      push_sample(1'b0, advance(0, 30));
    end
    // line noise between frames
    if ($urandom_range(7) == 0) begin
      n = $urandom_range(1, 5);
      repeat (n) push_sample(1'($urandom_range(1)), advance(0, 500));
    end
  endtask

  // wait for every request to be taken and every result to be checked
  task automatic drain();
    @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_colors.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_gap_threshold(input logic [GAP_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    gap_thr    = v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [GAP_W-1:0] thr_list [8];
    int unsigned      target;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed frame at the reset threshold: gap equal to then just over the
    // threshold, timestamp wrap inside a slot, low sum overflow, a slot with
    // no low time, and extreme timestamps
    push_sample(1'b0, 32'hFFFF_FF00);
    push_sample(1'b1, 32'hFFFF_FF7A);
    push_sample(1'b1, 32'hFFFF_FF7B);
    push_sample(1'b0, 32'hFFFF_FFF0);
    push_sample(1'b0, 32'hFFFF_FFFF);
    push_sample(1'b0, 32'h0000_0010);
    push_sample(1'b1, 32'h0000_0020);
    push_sample(1'b1, 32'h0000_0030);
    push_sample(1'b0, 32'h0000_0040);
    push_sample(1'b0, 32'h0000_0040);
    push_sample(1'b1, 32'h0000_0050);
    push_sample(1'b1, 32'h0000_0060);
    push_sample(1'b0, 32'hF000_0060);
    push_sample(1'b0, 32'hE000_0061);
    push_sample(1'b1, 32'hE000_0062);
    push_sample(1'b0, 32'hE000_0070);
    push_sample(1'b0, 32'hE000_00FF);
    push_sample(1'b1, 32'hE000_0100);
    push_sample(1'b1, 32'hE000_0101);
    push_sample(1'b0, 32'hE000_0102);
    push_sample(1'b0, 32'hE000_0201);
    push_sample(1'b1, 32'hE000_0202);
    push_sample(1'b1, 32'hE000_0203);
    push_sample(1'b0, 32'h0000_0000);
    drain();

    // threshold sweep, extremes included; idling mode rotates per phase
    thr_list = '{16'h0000, 16'hFFFF, 16'd1, 16'($urandom()), GAP_THRESHOLD_RESET,
                 16'($urandom_range(2, 300)), 16'hFFFF, 16'($urandom())};
    stim_ts = $urandom();
    for (int ph = 0; ph < 8; ph++) begin
      set_gap_threshold(thr_list[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      target = queued_count + 76;
      while (queued_count < target) push_frame();
      drain();
    end

    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### color_pulse_frame_decoder.f
rtl/core/cpfd_pkg.sv
rtl/core/color_pulse_frame_decoder.sv
dv/tb.sv
